@@ hw/rtl/tndq_pkg.sv @@
// Package for the timestamped note delay queue.
// Holds the stored note format, configuration bundle, register indexes and FSM states.
// No dependencies.
package tndq_pkg;

  localparam int unsigned PitchW   = 7;
  localparam int unsigned VelW     = 7;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegEnabled = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDelay   = 2'd1;

  // Input item kinds.
  localparam logic ActNote = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef struct packed {
    logic [PitchW-1:0] pitch;
    logic [VelW-1:0]   velocity;
    logic [TimeW-1:0]  rel_time;
  } entry_t;

  typedef struct packed {
    logic             enabled;
    logic [TimeW-1:0] delay;
    logic             clear;
  } cfg_t;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StFlush
  } state_e;

endpackage

@@ hw/rtl/timestamped_note_delay_queue.sv @@
// Timestamped note delay queue: delays note transactions by a configured time.
// Input channel takes notes (action 0) and ticks (action 1) under valid/stall.
// With the queue enabled a note is stored with its release time (timestamp plus
// delay, saturating) and gives no result; a note that finds the ring full is dropped.
// With the queue disabled a note comes straight out as one result flagged last.
// A tick releases, oldest first, every stored note due at or before its time and
// stops at the first note not yet due; the final released note is flagged last.
// Flow: a note to store is taken while idle; a pass-through note leaves via the flush
// state. A tick starts the walk, which releases one note per cycle while results are
// taken, set by the single read port of the note memory, then hands out the last one.
// Results sit in an output register; while the receiver stalls, the walk holds.
// Input stall is high while a tick or pass-through is in progress.
// Configuration channel (valid/ready, always ready): index 0 enable (any write
// empties the queue), index 1 delay. The user must write only while idle;
// the block does not enforce this. Reset: queue empty, enable 1, delay 0. The note
// memory needs no clearing pass. Depends on tndq_pkg, tndq_ctrl and tndq_ram.
module timestamped_note_delay_queue
  import tndq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [TimeW-1:0]    event_time_i,
  input  logic [PitchW-1:0]   pitch_i,
  input  logic [VelW-1:0]     velocity_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PitchW-1:0]   out_pitch_o,
  output logic [VelW-1:0]     out_velocity_o,
  output logic [TimeW-1:0]    out_time_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  logic             enabled_q, enabled_d;
  logic [TimeW-1:0] delay_q, delay_d;
  logic             cfg_write;
  cfg_t             cfg;

  logic             ram_we;
  logic [PtrW-1:0]  ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [PtrW-1:0]  ram_raddr;
  entry_t           ram_rdata;
  entry_t           out_entry;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    enabled_d = enabled_q;
    delay_d   = delay_q;
    if (cfg_write) begin
      if (cfg_index_i == RegEnabled) begin
        enabled_d = cfg_data_i[0];
      end else if (cfg_index_i == RegDelay) begin
        delay_d = cfg_data_i[TimeW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
      delay_q   <= '0;
    end else begin
      enabled_q <= enabled_d;
      delay_q   <= delay_d;
    end
  end

  assign cfg.enabled = enabled_q;
  assign cfg.delay   = delay_q;
  assign cfg.clear   = cfg_write && (cfg_index_i == RegEnabled);

  tndq_ctrl #(
    .QueueDepth(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .event_time_i(event_time_i),
    .pitch_i     (pitch_i),
    .velocity_i  (velocity_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_entry_o (out_entry),
    .out_last_o  (last_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tndq_ram #(
    .Width($bits(entry_t)),
    .Depth(QUEUE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_pitch_o    = out_entry.pitch;
  assign out_velocity_o = out_entry.velocity;
  assign out_time_o     = out_entry.rel_time;

  // A note is written to the store only in the cycle it is accepted.
  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (in_valid_i && !in_stall_o))
    else $error("note store written outside a note transaction");

  // The store is never read and written in the same cycle.
  a_rw_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("note store read and written together");

  // Within a multi-result burst the input side stays blocked.
  a_burst_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> in_stall_o)
    else $error("input accepted during a release burst");

  // A taken non-final result is followed by the next one in the next cycle.
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("release burst broke off before its final result");

endmodule

@@ hw/rtl/tndq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the note store of the delay queue. No dependencies.
module tndq_ram #(
  parameter int unsigned Width = 46,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tndq_ctrl.sv @@
// Queue controller: ring pointers, note insertion, tick release walk and output register.
// Depends on tndq_pkg; drives the ports of one tndq_ram instance.
module tndq_ctrl
  import tndq_pkg::*;
#(
  parameter int unsigned QueueDepth = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [TimeW-1:0]              event_time_i,
  input  logic [PitchW-1:0]             pitch_i,
  input  logic [VelW-1:0]               velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output entry_t                        out_entry_o,
  output logic                          out_last_o,
  output logic                          ram_we_o,
  output logic [$clog2(QueueDepth)-1:0] ram_waddr_o,
  output entry_t                        ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(QueueDepth)-1:0] ram_raddr_o,
  input  entry_t                        ram_rdata_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  state_e           state_q, state_d;
  logic [PtrW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [TimeW-1:0] tick_q, tick_d;
  entry_t           pend_q, pend_d;
  logic             have_pend_q, have_pend_d;
  logic             out_valid_q, out_valid_d;
  entry_t           out_q, out_d;
  logic             out_last_q, out_last_d;

  logic             accept;
  logic             out_free;
  logic             due;
  logic             queue_full;
  logic             advance;
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] rel_time;
  logic [PtrW-1:0]  rp_inc;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign due        = (ram_rdata_i.rel_time <= tick_q);
  assign queue_full = (ptr_inc(wp_q) == rp_q);
  assign rp_inc     = ptr_inc(rp_q);
  // The walk may act only when a pending released note can be handed on.
  assign advance    = !have_pend_q || out_free;

  // Release time saturates at the largest time value.
  assign sum      = {1'b0, event_time_i} + {1'b0, cfg_i.delay};
  assign rel_time = sum[TimeW] ? '1 : sum[TimeW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (action_i == ActNote) begin
            if (!cfg_i.enabled) begin
              state_d = StFlush;
            end
          end else if (rp_q != wp_q) begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (advance) begin
          if (due) begin
            state_d = (rp_inc != wp_q) ? StCheck : StFlush;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StFlush: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    wp_d        = wp_q;
    rp_d        = rp_q;
    tick_d      = tick_q;
    pend_d      = pend_q;
    have_pend_d = have_pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    out_last_d  = out_last_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_wdata_o = '{pitch: pitch_i, velocity: velocity_i, rel_time: rel_time};

    unique case (state_q)
      StIdle: begin
        have_pend_d = 1'b0;
        if (accept) begin
          if (action_i == ActNote) begin
            if (!cfg_i.enabled) begin
              pend_d = '{pitch: pitch_i, velocity: velocity_i, rel_time: event_time_i};
            end else if (!queue_full) begin
              ram_we_o = 1'b1;
              wp_d     = ptr_inc(wp_q);
            end
          end else begin
            tick_d   = event_time_i;
            ram_re_o = (rp_q != wp_q);
          end
        end
      end
      StCheck: begin
        if (advance) begin
          // The note held back is the last one when the entry behind it is not due.
          if (have_pend_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
            out_last_d  = !due;
          end
          have_pend_d = due;
          if (due) begin
            pend_d   = ram_rdata_i;
            rp_d     = rp_inc;
            ram_re_o = (rp_inc != wp_q);
          end
        end
      end
      StFlush: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          out_last_d  = 1'b1;
          have_pend_d = 1'b0;
        end
      end
      default: begin
        have_pend_d = 1'b0;
      end
    endcase

    if (cfg_i.clear) begin
      wp_d = '0;
      rp_d = '0;
    end
  end

  assign ram_waddr_o = wp_q;
  assign ram_raddr_o = rp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wp_q        <= '0;
      rp_q        <= '0;
      have_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      have_pend_q <= have_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q     <= tick_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_entry_o = out_q;
  assign out_last_o  = out_last_q;

endmodule
